/* rtl/llrd_pkg.sv */
`default_nettype none

package llrd_pkg;

    localparam int MAX_ENTRIES = 65536;
    localparam int IDX_W       = 17;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);

    localparam logic [IDX_W-1:0] MAX_IDX           = IDX_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] NUM_ENTRIES_RESET = IDX_W'(65536);

    localparam logic OP_REBUILD = 1'b0;
    localparam logic OP_REMOVE  = 1'b1;

    typedef struct packed {
        logic lookup;       // read both link stores at the accepted indices
        logic link;         // join the survivors and load the result register
        logic sweep_start;  // latch the entry count and restart the sweep counter
        logic sweep_step;   // write one entry of the fresh list
    } llrd_cmd_t;

    typedef struct packed {
        logic count_zero;   // the next rebuild would write nothing
        logic sweep_last;   // the sweep is on its last entry
    } llrd_status_t;

    // Entry k lives at memory address k-1
    function automatic logic [ADDR_W-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] off;
        off = idx - IDX_W'(1);
        return off[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/llrd_if.sv */
`default_nettype none

interface llrd_item_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [llrd_pkg::IDX_W-1:0]  first_index;
    logic [llrd_pkg::IDX_W-1:0]  last_index;

    modport source (output valid, operation, first_index, last_index, input ready);
    modport sink   (input valid, operation, first_index, last_index, output ready);
endinterface

interface llrd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        left_found;
    logic [llrd_pkg::IDX_W-1:0]  left_index;
    logic                        right_found;
    logic [llrd_pkg::IDX_W-1:0]  right_index;

    modport source (output valid, left_found, left_index, right_found, right_index,
                    input ready);
    modport sink   (input valid, left_found, left_index, right_found, right_index,
                    output ready);
endinterface

interface llrd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [llrd_pkg::IDX_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/llrd_ram.sv */
`default_nettype none

module llrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/llrd_datapath.sv */
`default_nettype none

module llrd_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [llrd_pkg::IDX_W-1:0]  cfg_data,
    input  wire logic [llrd_pkg::IDX_W-1:0]  first_index,
    input  wire logic [llrd_pkg::IDX_W-1:0]  last_index,
    input  wire llrd_pkg::llrd_cmd_t         cmd,
    output llrd_pkg::llrd_status_t           status,
    output logic                             left_found,
    output logic [llrd_pkg::IDX_W-1:0]       left_index,
    output logic                             right_found,
    output logic [llrd_pkg::IDX_W-1:0]       right_index
);

    logic [llrd_pkg::IDX_W-1:0]  num_entries_reg;
    logic [llrd_pkg::IDX_W-1:0]  count;
    logic [llrd_pkg::IDX_W-1:0]  n_reg;
    logic [llrd_pkg::IDX_W-1:0]  cnt_reg;
    logic                        range_ok_reg;
    logic                        range_ok;

    logic [llrd_pkg::IDX_W-1:0]  left_rdata;
    logic [llrd_pkg::IDX_W-1:0]  right_rdata;
    logic [llrd_pkg::IDX_W-1:0]  lft;
    logic [llrd_pkg::IDX_W-1:0]  rgt;

    logic                        left_we;
    logic [llrd_pkg::ADDR_W-1:0] left_waddr;
    logic [llrd_pkg::IDX_W-1:0]  left_wdata;
    logic                        right_we;
    logic [llrd_pkg::ADDR_W-1:0] right_waddr;
    logic [llrd_pkg::IDX_W-1:0]  right_wdata;

    logic                        left_found_reg;
    logic [llrd_pkg::IDX_W-1:0]  left_index_reg;
    logic                        right_found_reg;
    logic [llrd_pkg::IDX_W-1:0]  right_index_reg;

    // Saturate the count at the store depth
    assign count = (num_entries_reg > llrd_pkg::MAX_IDX) ? llrd_pkg::MAX_IDX
                                                         : num_entries_reg;

    assign range_ok = (first_index != '0) && (first_index <= llrd_pkg::MAX_IDX) &&
                      (last_index != '0) && (last_index <= llrd_pkg::MAX_IDX);

    assign status.count_zero = (count == '0);
    assign status.sweep_last = (cnt_reg == n_reg);

    // Drop links that point past the store, and everything for a bad index
    assign lft = (range_ok_reg && left_rdata <= llrd_pkg::MAX_IDX) ? left_rdata : '0;
    assign rgt = (range_ok_reg && right_rdata <= llrd_pkg::MAX_IDX) ? right_rdata : '0;

    always_comb
    begin
        left_we     = cmd.sweep_step || (cmd.link && rgt != '0);
        right_we    = cmd.sweep_step || (cmd.link && lft != '0);
        if (cmd.sweep_step)
        begin
            left_waddr  = llrd_pkg::idx_to_addr(cnt_reg);
            left_wdata  = cnt_reg - llrd_pkg::IDX_W'(1);
            right_waddr = llrd_pkg::idx_to_addr(cnt_reg);
            right_wdata = (cnt_reg == n_reg) ? '0 : cnt_reg + llrd_pkg::IDX_W'(1);
        end
        else
        begin
            left_waddr  = llrd_pkg::idx_to_addr(rgt);
            left_wdata  = lft;
            right_waddr = llrd_pkg::idx_to_addr(lft);
            right_wdata = rgt;
        end
    end

    llrd_ram #(
        .WIDTH (llrd_pkg::IDX_W),
        .DEPTH (llrd_pkg::MAX_ENTRIES)
    ) u_left_link (
        .clk   (clk),
        .we    (left_we),
        .waddr (left_waddr),
        .wdata (left_wdata),
        .re    (cmd.lookup),
        .raddr (llrd_pkg::idx_to_addr(first_index)),
        .rdata (left_rdata)
    );

    llrd_ram #(
        .WIDTH (llrd_pkg::IDX_W),
        .DEPTH (llrd_pkg::MAX_ENTRIES)
    ) u_right_link (
        .clk   (clk),
        .we    (right_we),
        .waddr (right_waddr),
        .wdata (right_wdata),
        .re    (cmd.lookup),
        .raddr (llrd_pkg::idx_to_addr(last_index)),
        .rdata (right_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_entries_reg <= llrd_pkg::NUM_ENTRIES_RESET;
        end
        else if (cfg_write)
        begin
            num_entries_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_start)
        begin
            n_reg   <= count;
            cnt_reg <= llrd_pkg::IDX_W'(1);
        end
        else if (cmd.sweep_step)
        begin
            cnt_reg <= cnt_reg + llrd_pkg::IDX_W'(1);
        end
        if (cmd.lookup)
        begin
            range_ok_reg <= range_ok;
        end
        if (cmd.link)
        begin
            left_found_reg  <= (lft != '0);
            left_index_reg  <= lft;
            right_found_reg <= (rgt != '0);
            right_index_reg <= rgt;
        end
    end

    assign left_found  = left_found_reg;
    assign left_index  = left_index_reg;
    assign right_found = right_found_reg;
    assign right_index = right_index_reg;

endmodule

`default_nettype wire

/* rtl/llrd_ctrl.sv */
`default_nettype none

module llrd_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    input  wire logic                    item_operation,
    output logic                         item_ready,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    input  wire llrd_pkg::llrd_status_t  status,
    output llrd_pkg::llrd_cmd_t          cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   item_accept;

    assign item_ready  = (state_reg == ST_IDLE);
    assign item_accept = item_valid && item_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (item_operation == llrd_pkg::OP_REMOVE)
                    begin
                        cmd.lookup = 1'b1;
                        state_next = ST_LINK;
                    end
                    else if (!status.count_zero)
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                end
            end
            ST_LINK:
            begin
                // Hold the read data until the result register frees up
                if (!out_valid_reg || result_ready)
                begin
                    cmd.link       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_result_from_link: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LINK))
        else $error("result word appeared without a link step");

    a_link_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK && (!out_valid_reg || result_ready)) |=>
            (out_valid_reg && state_reg == ST_IDLE))
        else $error("link step did not load a result word");

    a_sweep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && item_accept && item_operation == llrd_pkg::OP_REBUILD &&
         status.count_zero) |=> (state_reg == ST_IDLE))
        else $error("sweep entered with an empty list");
`endif

endmodule

`default_nettype wire

/* rtl/linked_list_range_delete.sv */
`default_nettype none

// Remove: taking the item word starts a registered read of both link stores; the link step then
// writes back the joins and loads the result word (it waits while an earlier result is not taken).
// Rebuild: n entries are swept, one write per link store a cycle; nothing is written if n is 0.
// Configuration words are taken every cycle; item words only while the controller is idle.
// Reset: controller idle, no result pending, num_entries at 65536; link stores hold
// nothing defined until the first rebuild.
module linked_list_range_delete (
    input  wire logic    clk,
    input  wire logic    rst_n,
    llrd_cfg_if.sink     cfg,
    llrd_item_if.sink    item,
    llrd_result_if.source result
);

    llrd_pkg::llrd_cmd_t    cmd;
    llrd_pkg::llrd_status_t status;

    assign cfg.ready = 1'b1;

    llrd_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item.valid),
        .item_operation (item.operation),
        .item_ready     (item.ready),
        .result_valid   (result.valid),
        .result_ready   (result.ready),
        .status         (status),
        .cmd            (cmd)
    );

    llrd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg.valid),
        .cfg_data    (cfg.data),
        .first_index (item.first_index),
        .last_index  (item.last_index),
        .cmd         (cmd),
        .status      (status),
        .left_found  (result.left_found),
        .left_index  (result.left_index),
        .right_found (result.right_found),
        .right_index (result.right_index)
    );

endmodule

`default_nettype wire

/* bench/llrd_survivor_checker.sv */
`timescale 1ns / 1ps

module llrd_survivor_checker
    import llrd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    llrd_cfg_if       cfg,
    llrd_item_if      item,
    llrd_result_if    result,
    output int        outstanding,
    output int        failures
);

    typedef struct packed {
        logic             left_found;
        logic [IDX_W-1:0] left_index;
        logic             right_found;
        logic [IDX_W-1:0] right_index;
    } survivors_t;

    bit [IDX_W-1:0] left_link  [1:MAX_ENTRIES];
    bit [IDX_W-1:0] right_link [1:MAX_ENTRIES];
    logic [IDX_W-1:0] entry_count;
    survivors_t expected_survivors [$];
    int mismatches;

    function automatic void relink_all();
        int n;
        int i;
        n = (entry_count > MAX_IDX) ? MAX_ENTRIES : int'(entry_count);
        for (i = 1; i <= n; i++)
        begin
            left_link[i]  = IDX_W'(i - 1);
            right_link[i] = (i == n) ? '0 : IDX_W'(i + 1);
        end
    endfunction

    function automatic survivors_t unlink_run(input logic [IDX_W-1:0] first,
                                              input logic [IDX_W-1:0] last);
        survivors_t s;
        logic [IDX_W-1:0] lft;
        logic [IDX_W-1:0] rgt;
        s = '0;
        // out-of-range indices leave the list alone and report no survivors
        if (first == '0 || first > MAX_IDX || last == '0 || last > MAX_IDX)
            return s;
        lft = left_link[first];
        rgt = right_link[last];
        if (lft > MAX_IDX)
            lft = '0;
        if (rgt > MAX_IDX)
            rgt = '0;
        // join the survivors; a missing side is never written
        if (rgt != '0)
            left_link[rgt] = lft;
        if (lft != '0)
            right_link[lft] = rgt;
        s.left_found  = (lft != '0);
        s.left_index  = lft;
        s.right_found = (rgt != '0);
        s.right_index = rgt;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        survivors_t want;
        if (!rst_n)
        begin
            entry_count = NUM_ENTRIES_RESET;
            expected_survivors.delete();
            mismatches = 0;
            outstanding <= 0;
            failures <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                entry_count = cfg.data;

            if (item.valid && item.ready)
            begin
                if (item.operation == OP_REBUILD)
                    relink_all();
                else
                    expected_survivors.insert(expected_survivors.size(),
                                              unlink_run(item.first_index,
                                                         item.last_index));
            end

            if (result.valid && result.ready)
            begin
                if (expected_survivors.size() == 0)
                begin
                    $error("result word with no remove outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_survivors.pop_front();
                    if (result.left_found !== want.left_found)
                    begin
                        $error("left_found: expected %0d, got %0d",
                               want.left_found, result.left_found);
                        mismatches++;
                    end
                    if (result.left_index !== want.left_index)
                    begin
                        $error("left_index: expected %0d, got %0d",
                               want.left_index, result.left_index);
                        mismatches++;
                    end
                    if (result.right_found !== want.right_found)
                    begin
                        $error("right_found: expected %0d, got %0d",
                               want.right_found, result.right_found);
                        mismatches++;
                    end
                    if (result.right_index !== want.right_index)
                    begin
                        $error("right_index: expected %0d, got %0d",
                               want.right_index, result.right_index);
                        mismatches++;
                    end
                end
            end

            outstanding <= expected_survivors.size();
            failures <= mismatches;
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import llrd_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int FIELD_TOP    = (1 << IDX_W) - 1;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 80;

    logic clk;
    logic rst_n;

    llrd_cfg_if    cfg_ch ();
    llrd_item_if   item_ch ();
    llrd_result_if result_ch ();

    int outstanding;
    int failures;

    logic [IDX_W-1:0] count_reg;
    int written_top;
    int last_count;
    int live [$];
    bit live_ok;
    bit calm;

    linked_list_range_delete dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    llrd_survivor_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .item        (item_ch),
        .result      (result_ch),
        .outstanding (outstanding),
        .failures    (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // result side: random stall before each word, none while calm
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    function automatic logic [IDX_W-1:0] any_field();
        return IDX_W'($urandom_range(0, FIELD_TOP));
    endfunction

    task automatic send_item(input logic op, input logic [IDX_W-1:0] first,
                             input logic [IDX_W-1:0] last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        // keep valid high across back-to-back words
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.first_index <= first;
        item_ch.last_index  <= last;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // hold until every result is in and any rebuild has finished sweeping
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (last_count + 8) @(posedge clk);
    endtask

    task automatic set_count(input logic [IDX_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        count_reg = value;
    endtask

    task automatic rebuild_list();
        int n;
        int k;
        n = (count_reg > MAX_IDX) ? MAX_ENTRIES : int'(count_reg);
        send_item(OP_REBUILD, any_field(), any_field());
        last_count = n;
        if (n > 0)
        begin
            live.delete();
            for (k = 1; k <= n; k++)
                live.insert(live.size(), k);
            live_ok = 1'b1;
            if (n > written_top)
                written_top = n;
        end
    endtask

    task automatic remove_live_run();
        int i;
        int room;
        int len;
        int first;
        int last;
        i = $urandom_range(0, live.size() - 1);
        room = live.size() - i;
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(1, room);
        else
            len = $urandom_range(1, (room < 3) ? room : 3);
        first = live[i];
        last  = live[i + len - 1];
        repeat (len) live.delete(i);
        send_item(OP_REMOVE, IDX_W'(first), IDX_W'(last));
    endtask

    // arbitrary run inside entries that hold links: may be dead or reversed
    task automatic remove_stray_run();
        int hi;
        hi = (last_count > 0 && $urandom_range(0, 3) != 0) ? last_count : written_top;
        live_ok = 1'b0;
        send_item(OP_REMOVE, IDX_W'($urandom_range(1, hi)), IDX_W'($urandom_range(1, hi)));
    endtask

    task automatic remove_out_of_range();
        logic [IDX_W-1:0] bad;
        logic [IDX_W-1:0] other;
        bad = ($urandom_range(0, 1) == 0) ? '0
                                          : IDX_W'($urandom_range(MAX_ENTRIES + 1, FIELD_TOP));
        other = any_field();
        if ($urandom_range(0, 1) == 0)
            send_item(OP_REMOVE, bad, other);
        else
            send_item(OP_REMOVE, other, bad);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (!live_ok && r < 40)
            remove_stray_run();
        else if (!live_ok || live.size() == 0 || r < 6)
            rebuild_list();
        else if (r < 12)
            remove_out_of_range();
        else if (r < 20)
            remove_stray_run();
        else
            remove_live_run();
    endtask

    initial
    begin
        int phase;
        int k;
        logic [IDX_W-1:0] next_count;

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        item_ch.valid = 1'b0;
        item_ch.operation = OP_REBUILD;
        item_ch.first_index = '0;
        item_ch.last_index = '0;
        count_reg = NUM_ENTRIES_RESET;
        written_top = 0;
        last_count = 0;
        live_ok = 1'b0;
        calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing linked yet: only indices that are out of range on both sides
        send_item(OP_REMOVE, '0, IDX_W'(FIELD_TOP));
        send_item(OP_REMOVE, IDX_W'(MAX_ENTRIES + 1), '0);

        // full-size list from the reset count
        rebuild_list();
        send_item(OP_REMOVE, '0, IDX_W'(5));
        send_item(OP_REMOVE, IDX_W'(3), IDX_W'(MAX_ENTRIES + 1));
        send_item(OP_REMOVE, IDX_W'(1), IDX_W'(1));
        send_item(OP_REMOVE, MAX_IDX, MAX_IDX);
        send_item(OP_REMOVE, IDX_W'(2), IDX_W'(MAX_ENTRIES - 1));
        send_item(OP_REMOVE, IDX_W'(40000), IDX_W'(30000));
        send_item(OP_REMOVE, MAX_IDX, IDX_W'(1));

        // zero count: the rebuild writes nothing
        set_count('0);
        rebuild_list();
        send_item(OP_REMOVE, IDX_W'(7), IDX_W'(7));

        set_count(IDX_W'(1));
        rebuild_list();
        send_item(OP_REMOVE, IDX_W'(1), IDX_W'(1));

        // count above the store size saturates
        set_count(IDX_W'(FIELD_TOP));
        rebuild_list();
        send_item(OP_REMOVE, IDX_W'(1), MAX_IDX);
        send_item(OP_REMOVE, IDX_W'(32768), IDX_W'(32768));
        send_item(OP_REMOVE, IDX_W'(32767), IDX_W'(32769));
        live_ok = 1'b0;

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       next_count = IDX_W'(1);
                1:       next_count = IDX_W'($urandom_range(1500, 3000));
                default: next_count = IDX_W'($urandom_range(2, 64));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            set_count(next_count);
            rebuild_list();
            for (k = 1; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    calm = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end

        drain();
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/llrd_pkg.sv
rtl/llrd_if.sv
rtl/llrd_ram.sv
rtl/llrd_datapath.sv
rtl/llrd_ctrl.sv
rtl/linked_list_range_delete.sv
bench/llrd_survivor_checker.sv
bench/testbench.sv
